### rtl/d2r_pkg.sv
package d2r_pkg;

   localparam int VALUE_WIDTH = 12;

   // One ASCII letter and the longest numeral (3888 has fifteen letters).
   localparam int LETTER_W  = 7;
   localparam int MAX_LEN   = 15;
   localparam int TEXT_W    = LETTER_W * MAX_LEN;
   localparam int GROUP_LEN = 4;
   localparam int GROUP_W   = LETTER_W * GROUP_LEN;
   localparam int MAX_ROMAN = 3999;

   localparam logic [LETTER_W-1:0] CH_I = 7'h49;
   localparam logic [LETTER_W-1:0] CH_V = 7'h56;
   localparam logic [LETTER_W-1:0] CH_X = 7'h58;
   localparam logic [LETTER_W-1:0] CH_L = 7'h4C;
   localparam logic [LETTER_W-1:0] CH_C = 7'h43;
   localparam logic [LETTER_W-1:0] CH_D = 7'h44;
   localparam logic [LETTER_W-1:0] CH_M = 7'h4D;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_ZERO  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   // Letters of one decimal digit, left-justified, with their count.
   typedef struct packed {
      logic [GROUP_W-1:0] text;
      logic [2:0]         len;
   } group_type;

   // Everything one word carries down the pipeline.
   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      status_type             status;
      logic [1:0]             thou;
      logic [3:0]             hund;
      logic [3:0]             tens;
      logic [3:0]             unit;
      logic [9:0]             rem;
      group_type              grp_tens;
      group_type              grp_unit;
      logic [TEXT_W-1:0]      text;
      logic [3:0]             count;
   } stage_type;

   function automatic group_type digit_group(input logic [3:0] d,
                                             input logic [LETTER_W-1:0] o,
                                             input logic [LETTER_W-1:0] f,
                                             input logic [LETTER_W-1:0] t);
      group_type g;
      g.text = '0;
      g.len  = 3'd0;
      case (d)
         4'd1: begin g.text = {o, 21'b0};       g.len = 3'd1; end
         4'd2: begin g.text = {o, o, 14'b0};    g.len = 3'd2; end
         4'd3: begin g.text = {o, o, o, 7'b0};  g.len = 3'd3; end
         4'd4: begin g.text = {o, f, 14'b0};    g.len = 3'd2; end
         4'd5: begin g.text = {f, 21'b0};       g.len = 3'd1; end
         4'd6: begin g.text = {f, o, 14'b0};    g.len = 3'd2; end
         4'd7: begin g.text = {f, o, o, 7'b0};  g.len = 3'd3; end
         4'd8: begin g.text = {f, o, o, o};     g.len = 3'd4; end
         4'd9: begin g.text = {o, t, 14'b0};    g.len = 3'd2; end
         default: begin g.text = '0;            g.len = 3'd0; end
      endcase
      return g;
   endfunction

   // Places a group behind the first n letters of a left-justified text.
   function automatic logic [TEXT_W-1:0] place_group(input logic [GROUP_W-1:0] g,
                                                     input logic [3:0] n);
      logic [TEXT_W-1:0] wide;
      wide = {g, {(TEXT_W - GROUP_W){1'b0}}};
      return wide >> (7'(n) * 7'd7);
   endfunction

endpackage

### rtl/decimal_to_roman_encoder_unit.sv
// Roman numeral encoder. Each word on the req_ channel carries one unsigned
// value; the unit answers with its Roman numeral in subtractive form (CM, CD,
// XC, XL, IX, IV), one ASCII letter per rsp_ word, most significant letter
// first, with rsp_last set on the final letter. A zero value gives one word
// with letter 0 and status "zero"; a value above 3999 gives one word with
// letter 0 and status "out of range". Nothing is kept between values. The
// value passes a six-stage pipeline (classify, thousands, hundreds, tens and
// units, letter groups, packing) and then sits in the output shift register,
// which hands out one letter per cycle while rsp_ready is high. A value thus
// gives as many rsp_ words as it has letters, 1 to 15, and the output shift
// register sets the sustained rate; the first letter reaches rsp_ after the
// six pipeline registers and the output register. The pipeline keeps taking
// new values while the output register drains, until it fills up.
module decimal_to_roman_encoder_unit
   import d2r_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [LETTER_W-1:0]    rsp_letter,
   output logic                   rsp_last,
   output logic [1:0]             rsp_status
);

   localparam int STAGES = 6;

   stage_type              pipe_ff [1:STAGES];
   stage_type              pipe_in [1:STAGES];
   logic [STAGES:1]        vld_ff;
   logic [STAGES+1:1]      adv;

   logic [TEXT_W-1:0]      buf_ff;
   logic [3:0]             cnt_ff;
   status_type             status_ff;
   logic                   busy_ff;
   logic                   ser_ready;

   // A stage takes a new word when it is empty or its word moves on.
   always_comb begin
      adv[STAGES+1] = ser_ready;
      for (int k = STAGES; k >= 1; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign req_ready = adv[1];

   // Stage 1: register the value and classify it.
   always_comb begin
      pipe_in[1]       = '0;
      pipe_in[1].value = req_value;
      if (req_value == '0) begin
         pipe_in[1].status = ST_ZERO;
      end else if (req_value > VALUE_WIDTH'(MAX_ROMAN)) begin
         pipe_in[1].status = ST_RANGE;
      end else begin
         pipe_in[1].status = ST_OK;
      end
   end

   // Stage 2: thousands digit and the remainder below 1000.
   always_comb begin
      pipe_in[2] = pipe_ff[1];
      if (pipe_ff[1].value >= VALUE_WIDTH'(3000)) begin
         pipe_in[2].thou = 2'd3;
      end else if (pipe_ff[1].value >= VALUE_WIDTH'(2000)) begin
         pipe_in[2].thou = 2'd2;
      end else if (pipe_ff[1].value >= VALUE_WIDTH'(1000)) begin
         pipe_in[2].thou = 2'd1;
      end else begin
         pipe_in[2].thou = 2'd0;
      end
      pipe_in[2].rem = 10'(pipe_ff[1].value - VALUE_WIDTH'(pipe_in[2].thou) *
                           VALUE_WIDTH'(1000));
   end

   // Stage 3: hundreds digit by parallel compares; remainder below 100.
   always_comb begin
      pipe_in[3]      = pipe_ff[2];
      pipe_in[3].hund = 4'd0;
      for (int k = 1; k <= 9; k++) begin
         if (pipe_ff[2].rem >= 10'(k * 100)) begin
            pipe_in[3].hund = 4'(k);
         end
      end
      pipe_in[3].rem = 10'(pipe_ff[2].rem - 10'(pipe_in[3].hund) * 10'd100);
   end

   // Stage 4: tens by reciprocal multiply (exact below 1029), then units.
   logic [14:0] tens_prod;
   always_comb begin
      pipe_in[4]      = pipe_ff[3];
      tens_prod       = 15'(pipe_ff[3].rem[6:0]) * 15'd205;
      pipe_in[4].tens = tens_prod[14:11];
      pipe_in[4].unit = 4'(pipe_ff[3].rem[6:0] - 7'(pipe_in[4].tens) * 7'd10);
   end

   // Stage 5: letter groups per digit; thousands and hundreds packed.
   group_type g_thou, g_hund;
   always_comb begin
      pipe_in[5]          = pipe_ff[4];
      g_thou              = digit_group({2'b0, pipe_ff[4].thou}, CH_M, CH_M, CH_M);
      g_hund              = digit_group(pipe_ff[4].hund, CH_C, CH_D, CH_M);
      pipe_in[5].grp_tens = digit_group(pipe_ff[4].tens, CH_X, CH_L, CH_C);
      pipe_in[5].grp_unit = digit_group(pipe_ff[4].unit, CH_I, CH_V, CH_X);
      pipe_in[5].text     = place_group(g_thou.text, 4'd0) |
                            place_group(g_hund.text, 4'(g_thou.len));
      pipe_in[5].count    = 4'(g_thou.len) + 4'(g_hund.len);
   end

   // Stage 6: tens and units appended; special cases become one blank word.
   logic [3:0] cnt_mid;
   always_comb begin
      pipe_in[6] = pipe_ff[5];
      cnt_mid    = pipe_ff[5].count + 4'(pipe_ff[5].grp_tens.len);
      if (pipe_ff[5].status == ST_OK) begin
         pipe_in[6].text  = pipe_ff[5].text |
                            place_group(pipe_ff[5].grp_tens.text, pipe_ff[5].count) |
                            place_group(pipe_ff[5].grp_unit.text, cnt_mid);
         pipe_in[6].count = cnt_mid + 4'(pipe_ff[5].grp_unit.len);
      end else begin
         pipe_in[6].text  = '0;
         pipe_in[6].count = 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[1]) begin
            vld_ff[1] <= req_valid;
         end
         for (int k = 2; k <= STAGES; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= STAGES; k++) begin
         if (adv[k]) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   // Output shift register: the front letter is always in the top slot.
   // It reloads on the cycle its final letter is taken.
   assign ser_ready = !busy_ff || (rsp_ready && cnt_ff == 4'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (ser_ready) begin
         busy_ff <= vld_ff[STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (ser_ready) begin
         buf_ff    <= pipe_ff[STAGES].text;
         cnt_ff    <= pipe_ff[STAGES].count;
         status_ff <= pipe_ff[STAGES].status;
      end else if (rsp_ready) begin
         buf_ff <= {buf_ff[TEXT_W-LETTER_W-1:0], {LETTER_W{1'b0}}};
         cnt_ff <= cnt_ff - 4'd1;
      end
   end

   assign rsp_valid  = busy_ff;
   assign rsp_letter = buf_ff[TEXT_W-1 -: LETTER_W];
   assign rsp_last   = (cnt_ff == 4'd1);
   assign rsp_status = status_ff;

endmodule
